@@ hw/rtl/steering_pd_speed_controller_assert.svh @@
// Assertion macros for the steering PD speed controller.
`ifndef STEERING_PD_SPEED_CONTROLLER_ASSERT_SVH
`define STEERING_PD_SPEED_CONTROLLER_ASSERT_SVH
`ifndef SYNTH
`define SPSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");
`define SPSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");
`else
`define SPSC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SPSC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hw/rtl/spsc_pkg.sv @@
// Types and constants of the steering PD speed controller.
package spsc_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROP,
        ST_DERV,
        ST_SQR,
        ST_SPEED
    } t_state;

    localparam logic [2:0] CFG_GAIN_P   = 3'd0;
    localparam logic [2:0] CFG_GAIN_D   = 3'd1;
    localparam logic [2:0] CFG_MAX_TURN = 3'd2;
    localparam logic [2:0] CFG_MAX_FWD  = 3'd3;
    localparam logic [2:0] CFG_MAX_REV  = 3'd4;

    localparam logic [15:0] RST_GAIN_P   = 16'd5120;
    localparam logic [15:0] RST_GAIN_D   = 16'd15411;
    localparam logic [14:0] RST_MAX_TURN = 15'd12868;
    localparam logic [14:0] RST_MAX_FWD  = 15'd24576;
    localparam logic [14:0] RST_MAX_REV  = 15'd8192;

    localparam logic signed [15:0] Q_PI     = 16'sd12868;
    localparam logic signed [15:0] Q_NEG_PI = -16'sd12868;
    localparam logic signed [15:0] Q_TWO_PI = 16'sd25736;

    localparam logic [18:0] DIST_NEAR   = 19'd9830;
    localparam logic [18:0] DIST_ARRIVE = 19'd1638;
    localparam logic [13:0] ERR_HALF_PI = 14'd6434;
    localparam logic [13:0] ERR_3Q_PI   = 14'd9650;
    localparam logic signed [22:0] CRAWL_SPEED = 23'sd2048;

    localparam logic [7:0] CELLS_ARRIVE = 8'd4;
    localparam logic [7:0] CELLS_CRAWL  = 8'd3;
    localparam logic [7:0] CELLS_GENTLE = 8'd6;

endpackage

@@ hw/rtl/steering_pd_speed_controller.sv @@
// Steering PD speed controller: wrapped heading error, PD turn command, speed rule.
// An accepted item steps through the PROP, DERV, SQR and SPEED states before the output register is loaded.
// A single 17x17 signed multiplier is stepped through three products per item
// (Kp*e, Kd*de, e*e); the block takes no item while it works, and holds in its last
// step while the output register keeps an item that is not taken. Synchronous
// active-low reset clears control, configuration to defaults and the stored errors.
`include "steering_pd_speed_controller_assert.svh"

module steering_pd_speed_controller #(
    parameter int ROBOTS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_robot_index,
    input  logic signed [14:0] i_heading,
    input  logic signed [14:0] i_target_bearing,
    input  logic [18:0]        i_target_distance,
    input  logic [7:0]         i_cells_left,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_turn_command,
    output logic signed [15:0] o_speed_command,
    output logic signed [14:0] o_heading_error,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import spsc_pkg::*;

    localparam int SW = (ROBOTS > 1) ? $clog2(ROBOTS) : 1;
    localparam logic [4:0] ROBOTS_W = 5'(ROBOTS);

    t_state r_state, n_state;

    logic [15:0] r_gain_p, r_gain_d;
    logic [14:0] r_max_turn, r_max_fwd, r_max_rev;

    logic signed [15:0] r_prev [ROBOTS];

    logic [SW-1:0]      r_slot;
    logic signed [14:0] r_err;
    logic [18:0]        r_dist;
    logic [7:0]         r_cells;
    logic signed [15:0] r_diff;
    logic               r_arrive, r_crawl, r_stop, r_near, r_gentle;
    logic [16:0]        r_lin;
    logic signed [33:0] r_acc;
    logic signed [15:0] r_turn;
    logic [32:0]        r_sqt;

    logic               r_out_valid;
    logic signed [15:0] r_turn_out, r_speed_out;
    logic signed [14:0] r_err_out;

    // control
    logic               accept, out_free, load_out;
    logic signed [16:0] mul_a, mul_b;
    logic signed [33:0] prod;

    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_valid) n_state = ST_PROP;
            ST_PROP:  n_state = ST_DERV;
            ST_DERV:  n_state = ST_SQR;
            ST_SQR:   n_state = ST_SPEED;
            ST_SPEED: if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready  = 1'b0;
        load_out = 1'b0;
        mul_a    = $signed({r_err[14], r_err[14], r_err});
        mul_b    = $signed({r_err[14], r_err[14], r_err});
        unique case (r_state)
            ST_IDLE:  o_ready = i_rst_n;
            ST_PROP:  mul_a = $signed({1'b0, r_gain_p});
            ST_DERV: begin
                mul_a = $signed({1'b0, r_gain_d});
                mul_b = $signed({r_diff[15], r_diff});
            end
            ST_SQR:   ;
            ST_SPEED: load_out = out_free;
            default:  ;
        endcase
    end

    assign prod = mul_a * mul_b;

    // slot = robot_index mod ROBOTS
    logic [4:0]    m0, m1, m2, m3;
    logic [SW-1:0] slot_in;
    always_comb begin
        m0 = {3'b000, i_robot_index};
        m1 = (m0 >= ROBOTS_W) ? m0 - ROBOTS_W : m0;
        m2 = (m1 >= ROBOTS_W) ? m1 - ROBOTS_W : m1;
        m3 = (m2 >= ROBOTS_W) ? m2 - ROBOTS_W : m2;
        slot_in = m3[SW-1:0];
    end

    // wrap heading - bearing into (-pi, pi]
    logic signed [15:0] d, d_lo, d_hi, err_w;
    always_comb begin
        d     = $signed({i_heading[14], i_heading})
              - $signed({i_target_bearing[14], i_target_bearing});
        d_lo  = d - Q_TWO_PI;
        d_hi  = d + Q_TWO_PI;
        if (d >= Q_PI) begin
            err_w = (d == Q_PI) ? d : d_lo;
        end else begin
            err_w = (d <= Q_NEG_PI) ? d_hi : d;
        end
    end

    // flags from the stored error, distance and cell count
    logic signed [14:0] neg_err;
    logic [13:0]        mag;
    logic               arrive_c, crawl_c, stop_c, near_c, gentle_c;
    logic [16:0]        lin_c;
    logic signed [15:0] diff_c;
    always_comb begin
        neg_err  = -r_err;
        mag      = r_err[14] ? neg_err[13:0] : r_err[13:0];
        arrive_c = (r_dist <= DIST_ARRIVE) && (r_cells <= CELLS_ARRIVE);
        crawl_c  = ((mag >= ERR_HALF_PI) && (mag <= ERR_3Q_PI))
                || ((r_dist <= DIST_ARRIVE) && (r_cells <= CELLS_CRAWL));
        stop_c   = mag > ERR_3Q_PI;
        near_c   = r_dist <= DIST_NEAR;
        gentle_c = r_cells <= CELLS_GENTLE;
        lin_c    = gentle_c ? {1'b0, r_dist[13:0], 2'b00}
                            : {1'b0, r_dist[13:0], 2'b00} + {2'b00, r_dist[13:0], 1'b0};
        diff_c   = $signed({r_err[14], r_err}) - r_prev[r_slot];
    end

    // turn: round -sum/256, arrival zero, clamp; scaled error square for the speed rule
    logic signed [34:0] neg_acc;
    logic signed [26:0] turn_raw, turn_arr, turn_max, turn_clip;
    logic [27:0]        sq;
    logic [32:0]        sqt_c;
    always_comb begin
        neg_acc  = -$signed({r_acc[33], r_acc}) + 35'sd128;
        turn_raw = neg_acc[34:8];
        turn_arr = r_arrive ? 27'sd0 : turn_raw;
        turn_max = $signed({12'b0, r_max_turn});
        if (turn_arr <= -turn_max) begin
            turn_clip = -turn_max;
        end else if (turn_arr >= turn_max) begin
            turn_clip = turn_max;
        end else begin
            turn_clip = turn_arr;
        end
        sq    = prod[27:0];
        sqt_c = r_gentle ? {4'b0, sq, 1'b0} + {5'b0, sq}
                         : {1'b0, sq, 4'b0} + {3'b0, sq, 2'b00};
    end

    // speed rule
    logic signed [34:0] v;
    logic signed [22:0] rnd, base, sel, sp, fwd, rev;
    always_comb begin
        v    = $signed({6'b0, r_lin, 12'h800}) - $signed({2'b00, r_sqt});
        rnd  = v[34:12];
        fwd  = $signed({8'b0, r_max_fwd});
        rev  = -$signed({8'b0, r_max_rev});
        base = r_near ? (rnd[22] ? 23'sd0 : rnd) : fwd;
        if (r_crawl) begin
            sel = CRAWL_SPEED;
        end else if (r_stop) begin
            sel = 23'sd0;
        end else begin
            sel = base;
        end
        sp = (sel > fwd) ? fwd : sel;
        if (sp < rev) sp = rev;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_gain_p    <= RST_GAIN_P;
            r_gain_d    <= RST_GAIN_D;
            r_max_turn  <= RST_MAX_TURN;
            r_max_fwd   <= RST_MAX_FWD;
            r_max_rev   <= RST_MAX_REV;
            for (int i = 0; i < ROBOTS; i++) r_prev[i] <= '0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_GAIN_P:   r_gain_p   <= i_cfg_data;
                    CFG_GAIN_D:   r_gain_d   <= i_cfg_data;
                    CFG_MAX_TURN: r_max_turn <= i_cfg_data[14:0];
                    CFG_MAX_FWD:  r_max_fwd  <= i_cfg_data[14:0];
                    CFG_MAX_REV:  r_max_rev  <= i_cfg_data[14:0];
                    default:      ;
                endcase
            end
            if (r_state == ST_PROP) begin
                r_prev[r_slot] <= arrive_c ? 16'sd0 : $signed({r_err[14], r_err});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_slot  <= slot_in;
            r_err   <= err_w[14:0];
            r_dist  <= i_target_distance;
            r_cells <= i_cells_left;
        end
        case (r_state)
            ST_PROP: begin
                r_acc    <= prod;
                r_diff   <= diff_c;
                r_arrive <= arrive_c;
                r_crawl  <= crawl_c;
                r_stop   <= stop_c;
                r_near   <= near_c;
                r_gentle <= gentle_c;
                r_lin    <= lin_c;
            end
            ST_DERV: r_acc <= r_acc + prod;
            ST_SQR: begin
                r_turn <= turn_clip[15:0];
                r_sqt  <= sqt_c;
            end
            default: ;
        endcase
        if (load_out) begin
            r_turn_out  <= r_turn;
            r_speed_out <= sp[15:0];
            r_err_out   <= r_err;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_turn_command  = r_turn_out;
    assign o_speed_command = r_speed_out;
    assign o_heading_error = r_err_out;

    logic signed [15:0] w_turn_lim;
    logic               w_turn_ok, w_arrive_chk, w_full_stall;
    assign w_turn_lim   = $signed({1'b0, r_max_turn});
    assign w_turn_ok    = (o_turn_command <= w_turn_lim) && (o_turn_command >= -w_turn_lim);
    assign w_arrive_chk = (r_state == ST_DERV) && r_arrive;
    assign w_full_stall = (r_state == ST_SPEED) && r_out_valid && !i_ready;

    `SPSC_ASSERT_NOW(a_arrive_clears, i_clk, i_rst_n, w_arrive_chk, r_prev[r_slot] == 16'sd0)
    `SPSC_ASSERT_NOW(a_turn_limit, i_clk, i_rst_n, o_valid, w_turn_ok)
    `SPSC_ASSERT_NOW(a_speed_nonneg, i_clk, i_rst_n, o_valid, !o_speed_command[15])
    `SPSC_ASSERT_NEXT(a_hold_when_full, i_clk, i_rst_n, w_full_stall, r_state == ST_SPEED)

endmodule
